/* sv/smm_pkg.sv */
// Shared types and constants for the stick, arming and motor mixer block.
package smm_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_YAW_CENTER   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_CENTER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROLL_CENTER  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KILL_CODE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GESTURE_TH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_FLOOR  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_CEIL   = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_YAW_CENTER   = 16'd2050;
  localparam logic [15:0] RST_PITCH_CENTER = 16'd2065;
  localparam logic [15:0] RST_ROLL_CENTER  = 16'd2110;
  localparam logic [15:0] RST_KILL_CODE    = 16'd8000;
  localparam logic [10:0] RST_GESTURE_TH   = 11'd1950;
  localparam logic [15:0] RST_MOTOR_FLOOR  = 16'd4400;
  localparam logic [15:0] RST_MOTOR_CEIL   = 16'd8000;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 120;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // Mixer constants
  localparam logic [15:0] IDLE_COMPARE = 16'd4000;
  localparam logic [15:0] DIV5_RECIP   = 16'd52429;  // ceil(2^18 / 5)

  typedef struct packed {
    logic [15:0] yaw_center;
    logic [15:0] pitch_center;
    logic [15:0] roll_center;
    logic [15:0] kill_code;
    logic [10:0] gesture_th;
    logic [15:0] motor_floor;
    logic [15:0] motor_ceiling;
  } cfg_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic               tick;
    logic        [11:0] thr;
    logic signed [11:0] yaw;
    logic signed [11:0] pitch;
    logic signed [11:0] roll;
    logic               armed;
    logic signed [13:0] p_drv;
    logic signed [13:0] r_drv;
    logic signed [13:0] y_drv;
  } queue_entry_t;

endpackage

/* sv/smm_front.sv */
// Front part: stick conditioning, kill code and arming gestures, one item a cycle while the queue is not full.
module smm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smm_pkg::cfg_t                cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [smm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  logic                         q_full,
  output logic                         q_push,
  output smm_pkg::queue_entry_t        q_entry
);
  import smm_pkg::*;

  localparam logic signed [15:0] STICK_MAX = 16'sd2001;
  localparam logic signed [15:0] STICK_LIM = 16'sd2000;

  // Deadband bounds (exclusive) per axis
  localparam logic signed [15:0] YAW_LO   = -16'sd6;
  localparam logic signed [15:0] YAW_HI   = 16'sd8;
  localparam logic signed [15:0] PITCH_LO = -16'sd4;
  localparam logic signed [15:0] PITCH_HI = 16'sd8;
  localparam logic signed [15:0] ROLL_LO  = -16'sd5;
  localparam logic signed [15:0] ROLL_HI  = 16'sd5;

  localparam logic signed [15:0] THR_LOW  = 16'sd4;
  localparam logic signed [15:0] THR_HIGH = 16'sd4001;
  localparam logic        [11:0] THR_MAX  = 12'd4000;

  function automatic logic signed [11:0] stick_cond(input logic signed [15:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [15:0] r;
    r = v;
    if (v > lo && v < hi) r = '0;
    if (r > STICK_MAX) r = STICK_LIM;
    else if (r < -STICK_MAX) r = -STICK_LIM;
    return r[11:0];
  endfunction

  logic        [11:0] thr_r, thr_nxt;
  logic signed [11:0] yaw_r, yaw_nxt;
  logic signed [11:0] pitch_r, pitch_nxt;
  logic signed [11:0] roll_r, roll_nxt;
  logic               armed_r, armed_nxt;

  logic               accept, tick, kill;
  logic signed [15:0] t_raw;
  logic        [11:0] thr_new;
  logic signed [12:0] th, yaw_e, pitch_e, roll_e;
  logic               armed_k, arm_go, armed_a, disarm_go;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign tick      = in_tuser;
  assign t_raw     = $signed(in_tdata[15:0]);

  // Throttle clamp
  always_comb begin
    if (t_raw < THR_LOW) thr_new = '0;
    else if (t_raw > THR_HIGH) thr_new = THR_MAX;
    else thr_new = t_raw[11:0];
  end

  // New stick holds; a tick keeps them, the kill code keeps roll
  assign kill = !tick && (in_tdata[63:48] == cfg.kill_code);

  always_comb begin
    thr_nxt   = thr_r;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    if (!tick) begin
      thr_nxt   = thr_new;
      yaw_nxt   = stick_cond($signed(in_tdata[31:16] - cfg.yaw_center), YAW_LO, YAW_HI);
      pitch_nxt = stick_cond($signed(in_tdata[47:32] - cfg.pitch_center), PITCH_LO,
                             PITCH_HI);
      if (!kill) begin
        roll_nxt = stick_cond($signed(in_tdata[63:48] - cfg.roll_center), ROLL_LO, ROLL_HI);
      end
    end
  end

  // Arm gesture first, then disarm gesture on the updated flag
  assign th      = $signed({2'b00, cfg.gesture_th});
  assign yaw_e   = {yaw_nxt[11], yaw_nxt};
  assign pitch_e = {pitch_nxt[11], pitch_nxt};
  assign roll_e  = {roll_nxt[11], roll_nxt};
  assign armed_k = kill ? 1'b0 : armed_r;
  assign arm_go  = !armed_k && (thr_nxt == '0) && (yaw_e >= th) && (pitch_e <= -th) &&
                   (roll_e >= th);
  assign armed_a = armed_k || arm_go;
  assign disarm_go = armed_a && (thr_nxt == '0) && (yaw_e <= -th) && (pitch_e <= -th) &&
                     (roll_e <= -th);
  assign armed_nxt = armed_a && !disarm_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
      armed_r <= 1'b0;
    end else if (accept) begin
      thr_r   <= thr_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Classified request to the back part
  assign q_push = accept;
  always_comb begin
    q_entry.tick  = tick;
    q_entry.thr   = thr_nxt;
    q_entry.yaw   = yaw_nxt;
    q_entry.pitch = pitch_nxt;
    q_entry.roll  = roll_nxt;
    q_entry.armed = armed_nxt;
    q_entry.p_drv = $signed(in_tdata[77:64]);
    q_entry.r_drv = $signed(in_tdata[91:78]);
    q_entry.y_drv = $signed(in_tdata[105:92]);
  end

endmodule

/* sv/smm_queue.sv */
// Short queue of classified requests between front and back.
module smm_queue #(
  parameter int DEPTH = smm_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  smm_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output smm_pkg::queue_entry_t pop_entry
);
  import smm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  queue_entry_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

/* sv/smm_back.sv */
// Back part: motor mixer pipeline, stored motor sums, compare clamp and output register.
module smm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smm_pkg::cfg_t                 cfg,
  input  logic                          q_not_empty,
  input  smm_pkg::queue_entry_t         q_entry,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [smm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import smm_pkg::*;

  localparam logic signed [19:0] MIX_BASE  = 20'sd4000;
  localparam logic signed [23:0] MIX2_BASE = 24'sd640000;  // 160 * base

  // Divide by 8, truncated toward zero
  function automatic logic signed [17:0] div8(input logic signed [19:0] n);
    logic signed [19:0] a;
    a = n[19] ? n + 20'sd7 : n;
    return {a[19], a[19:3]};
  endfunction

  // Compare value for one motor
  function automatic logic [15:0] motor_cmp(input logic signed [17:0] s,
                                            input logic armed,
                                            input logic [15:0] floor_v,
                                            input logic [15:0] ceil_v);
    logic signed [18:0] se, ce1, fe;
    se  = {s[17], s};
    ce1 = $signed({3'b000, ceil_v}) + 19'sd1;
    fe  = $signed({3'b000, floor_v});
    if (!armed) return IDLE_COMPARE;
    else if (se > ce1) return ceil_v;
    else if (se <= fe) return floor_v;
    else return s[15:0];
  endfunction

  logic adv;

  // Stage 1 registers
  logic               s1_valid_r;
  queue_entry_t       s1_e_r;
  logic signed [17:0] s1_sum1_r, s1_sum3_r, s1_sum4_r;
  logic        [17:0] s1_mag_r;
  logic               s1_neg_r;

  // Stage 2 registers
  logic               s2_valid_r;
  queue_entry_t       s2_e_r;

  logic signed [17:0] sums_r [4];
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Whole back pipeline moves when the output register can take a result
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && q_not_empty;

  // Stage 1 arithmetic: numerators from throttle and drives
  logic signed [19:0] t5, p20, r20, y20;
  logic signed [23:0] t5w, d24, inner, n2, mag24;

  assign t5  = $signed({8'b0, q_entry.thr}) + $signed({6'b0, q_entry.thr, 2'b00});
  assign p20 = {{6{q_entry.p_drv[13]}}, q_entry.p_drv};
  assign r20 = {{6{q_entry.r_drv[13]}}, q_entry.r_drv};
  assign y20 = {{6{q_entry.y_drv[13]}}, q_entry.y_drv};
  assign t5w = {{4{t5[19]}}, t5};
  assign d24 = {{4{p20[19]}}, p20} + {{4{r20[19]}}, r20} - {{4{y20[19]}}, y20};
  assign inner = t5w + (d24 <<< 3);
  assign n2    = MIX2_BASE + (inner <<< 4) + (inner <<< 1) + inner;
  assign mag24 = n2[23] ? -n2 : n2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e_r    <= q_entry;
      s1_sum1_r <= div8(((MIX_BASE - p20 - r20 - y20) <<< 3) + t5);
      s1_sum3_r <= div8(((MIX_BASE - p20 + r20 + y20) <<< 3) + t5);
      s1_sum4_r <= div8(((MIX_BASE + p20 - r20 + y20) <<< 3) + t5);
      s1_mag_r  <= mag24[22:5];
      s1_neg_r  <= n2[23];
    end
  end

  // Stage 2: finish motor two by reciprocal multiply, commit sums on tick items
  logic [33:0]        prod;
  logic [15:0]        q5;
  logic signed [17:0] sum2;

  assign prod = 34'(s1_mag_r) * 34'(DIV5_RECIP);
  assign q5   = prod[33:18];
  assign sum2 = s1_neg_r ? -$signed({2'b00, q5}) : $signed({2'b00, q5});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) sums_r[i] <= '0;
    end else if (adv && s1_valid_r && s1_e_r.tick) begin
      sums_r[0] <= s1_sum1_r;
      sums_r[1] <= sum2;
      sums_r[2] <= s1_sum3_r;
      sums_r[3] <= s1_sum4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s2_e_r <= s1_e_r;
  end

  // Output register: stick holds, armed flag and clamped compares
  logic [OUT_TDATA_W-1:0] out_nxt;
  always_comb begin
    out_nxt         = '0;
    out_nxt[11:0]   = s2_e_r.thr;
    out_nxt[23:12]  = s2_e_r.yaw;
    out_nxt[35:24]  = s2_e_r.pitch;
    out_nxt[47:36]  = s2_e_r.roll;
    out_nxt[48]     = s2_e_r.armed;
    out_nxt[64:49]  = motor_cmp(sums_r[0], s2_e_r.armed, cfg.motor_floor, cfg.motor_ceiling);
    out_nxt[80:65]  = motor_cmp(sums_r[1], s2_e_r.armed, cfg.motor_floor, cfg.motor_ceiling);
    out_nxt[96:81]  = motor_cmp(sums_r[2], s2_e_r.armed, cfg.motor_floor, cfg.motor_ceiling);
    out_nxt[112:97] = motor_cmp(sums_r[3], s2_e_r.armed, cfg.motor_floor, cfg.motor_ceiling);
  end

  always_ff @(posedge clk) begin
    if (adv) out_tdata_r <= out_nxt;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_not_empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* sv/stick_arming_motor_mixer_unit.sv */
// Top level: configuration registers, front part, request queue and mixer back part.
//
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready  in_tdata (raw words, drives), in_tuser (mode)
// out_     master     out_tvalid / out_tready out_tdata (stick holds, armed, motors)
// cfg_     slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while the queue is not full; the rate is set by the front part, which
// updates the stick holds and arming flag once per request.
// After its request is taken, a result passes the queue, stage 1, stage 2 and the output register.
// Reset (rst_n low, synchronous) clears holds, arming, motor sums and queue; registers
// return to defaults. cfg_ready is always high.
// An output stall holds the back pipeline; the queue keeps taking requests until full.
module stick_arming_motor_mixer_unit #(
  parameter int QUEUE_DEPTH = smm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] raw_throttle, [31:16] raw_yaw, [47:32] raw_pitch, [63:48] raw_roll,
  // [77:64] rate_pitch_drive, [91:78] rate_roll_drive, [105:92] rate_yaw_drive
  input  logic [smm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] mode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] throttle_cmd, [23:12] yaw_cmd, [35:24] pitch_cmd, [47:36] roll_cmd,
  // [48] armed, [64:49] motor_one, [80:65] motor_two, [96:81] motor_three,
  // [112:97] motor_four
  output logic [smm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);
  import smm_pkg::*;

  cfg_t cfg_r;

  // Configuration register file
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yaw_center    <= RST_YAW_CENTER;
      cfg_r.pitch_center  <= RST_PITCH_CENTER;
      cfg_r.roll_center   <= RST_ROLL_CENTER;
      cfg_r.kill_code     <= RST_KILL_CODE;
      cfg_r.gesture_th    <= RST_GESTURE_TH;
      cfg_r.motor_floor   <= RST_MOTOR_FLOOR;
      cfg_r.motor_ceiling <= RST_MOTOR_CEIL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_YAW_CENTER:   cfg_r.yaw_center    <= cfg_data;
        CFG_PITCH_CENTER: cfg_r.pitch_center  <= cfg_data;
        CFG_ROLL_CENTER:  cfg_r.roll_center   <= cfg_data;
        CFG_KILL_CODE:    cfg_r.kill_code     <= cfg_data;
        CFG_GESTURE_TH:   cfg_r.gesture_th    <= cfg_data[10:0];
        CFG_MOTOR_FLOOR:  cfg_r.motor_floor   <= cfg_data;
        CFG_MOTOR_CEIL:   cfg_r.motor_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  logic         q_full, q_push, q_pop, q_not_empty;
  queue_entry_t q_push_entry, q_pop_entry;

  smm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_push_entry)
  );

  smm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (q_pop_entry)
  );

  smm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_entry     (q_pop_entry),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
